>>> rtl/core/integer_alu_with_carry_macros.svh
// Assertion macros shared by the integer ALU RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef INTEGER_ALU_WITH_CARRY_MACROS_SVH
`define INTEGER_ALU_WITH_CARRY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IAC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer ALU assertion failed");
`define IAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer ALU assertion failed");
`else
`define IAC_ASSERT_IMPLY(lbl, ante, cons)
`define IAC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/iac_pkg.sv
// Package for the integer ALU: operation and status codes, sequencer states
// and port width constants. Depends on nothing.
package iac_pkg;

  localparam int OP_W = 4;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int DEFAULT_WIDTH = 32;
  localparam int MAX_WIDTH = 64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_XOR = 4'd7,
    OP_LSH = 4'd8,
    OP_RSH = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_SHIFT     = 2'd2,
    ST_UNHANDLED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

>>> rtl/core/integer_alu_with_carry.sv
// Integer ALU with a kept carry flag; mul, and div or mod by a nonzero divisor, iterate WIDTH
// times on one shared adder. A transaction is captured in idle, evaluated in exec, iterated in
// the mul or div state where needed and loaded into the output register from finish; in_stall
// stays high until the sequencer is back in idle, so the next transaction waits for that load.
// Synchronous active-high reset clears the carry flag, the sequencer state and out_valid and
// holds the input stalled.
`include "integer_alu_with_carry_macros.svh"

module integer_alu_with_carry #(
  parameter int WIDTH = iac_pkg::DEFAULT_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [iac_pkg::OP_W-1:0]      operation,
  input  logic [iac_pkg::DATA_W-1:0]    first_operand,
  input  logic [iac_pkg::DATA_W-1:0]    second_operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iac_pkg::DATA_W-1:0]    result_value,
  output logic                          carry_out,
  output logic [iac_pkg::STATUS_W-1:0]  status
);
  import iac_pkg::*;

  localparam int SHW = $clog2(WIDTH);
  localparam int CW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] SIGN_MIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
  localparam logic [WIDTH-1:0] WIDTH_VAL = WIDTH'(WIDTH);

  state_t state, state_next;

  logic [OP_W-1:0]     op;
  logic [WIDTH-1:0]    a, b, hi, lo, rem, res;
  logic [CW-1:0]       cnt;
  logic                res_carry;
  logic [STATUS_W-1:0] res_status;
  logic                carry_flag;

  logic [MAX_WIDTH-1:0] ext_a, ext_b, res_ext;

  logic [WIDTH:0]   add_x, add_y;
  logic             add_cin;
  logic [WIDTH+1:0] add_sum;

  logic [WIDTH-1:0]    exec_res;
  logic                exec_carry;
  logic [STATUS_W-1:0] exec_status;
  logic [WIDTH-1:0]    div_rem_next, div_q_next;
  logic                out_load;

  assign ext_a = MAX_WIDTH'(first_operand);
  assign ext_b = MAX_WIDTH'(second_operand);
  assign res_ext = MAX_WIDTH'(res);
  assign add_sum = (WIDTH+2)'(add_x) + (WIDTH+2)'(add_y) + (WIDTH+2)'(add_cin);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (op == OP_MUL) begin
          state_next = S_MUL;
        end else if ((op == OP_DIV || op == OP_MOD) && b != '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL, S_DIV: begin
        if (cnt == '0) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = rst || (state != S_IDLE);
    out_load = (state == S_FINISH) && (!out_valid || !out_stall);
    add_x = '0;
    add_y = '0;
    add_cin = 1'b0;
    unique case (state)
      S_EXEC: begin
        add_x = {1'b0, a};
        if (op == OP_SUB) begin
          add_y = ~{1'b0, b};
          add_cin = 1'b1;
        end else begin
          add_y = {1'b0, b};
        end
      end
      S_MUL: begin
        add_x = {1'b0, hi};
        add_y = lo[0] ? {1'b0, a} : '0;
      end
      S_DIV: begin
        add_x = {rem, lo[WIDTH-1]};
        add_y = ~{1'b0, b};
        add_cin = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase

    div_q_next = {lo[WIDTH-2:0], add_sum[WIDTH+1]};
    div_rem_next = add_sum[WIDTH+1] ? add_sum[WIDTH-1:0] : {rem[WIDTH-2:0], lo[WIDTH-1]};

    exec_res = '0;
    exec_carry = carry_flag;
    exec_status = ST_OK;
    unique case (op)
      OP_ADD: begin
        exec_res = add_sum[WIDTH-1:0];
        exec_carry = add_sum[WIDTH];
      end
      OP_SUB: begin
        exec_res = add_sum[WIDTH-1:0];
        exec_carry = ~add_sum[WIDTH+1];
      end
      OP_MUL: exec_res = '0;
      OP_DIV, OP_MOD: begin
        if (b == '0) exec_status = ST_DIVZERO;
      end
      OP_AND: exec_res = a & b;
      OP_OR:  exec_res = a | b;
      OP_XOR: exec_res = a ^ b;
      OP_LSH: begin
        if (b >= WIDTH_VAL) exec_status = ST_SHIFT;
        else exec_res = a << b[SHW-1:0];
      end
      OP_RSH: begin
        if (b < WIDTH_VAL) exec_res = a >> b[SHW-1:0];
      end
      default: exec_status = ST_UNHANDLED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      carry_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        carry_flag <= res_carry;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= res_ext[DATA_W-1:0];
      carry_out <= res_carry;
      status <= res_status;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op <= operation;
          a <= ext_a[WIDTH-1:0];
          b <= ext_b[WIDTH-1:0];
        end
      end
      S_EXEC: begin
        res <= exec_res;
        res_carry <= exec_carry;
        res_status <= exec_status;
        hi <= '0;
        rem <= '0;
        lo <= (op == OP_MUL) ? b : a;
        cnt <= CW'(WIDTH - 1);
      end
      S_MUL: begin
        hi <= add_sum[WIDTH:1];
        lo <= {add_sum[0], lo[WIDTH-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          res <= {add_sum[0], lo[WIDTH-1:1]};
          res_carry <= (add_sum[WIDTH:1] != '0);
        end
      end
      S_DIV: begin
        rem <= div_rem_next;
        lo <= div_q_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          if (op == OP_DIV) begin
            res <= div_q_next;
            res_carry <= (a == SIGN_MIN) && (b == ALL_ONES);
          end else begin
            res <= div_rem_next;
          end
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  `IAC_ASSERT_IMPLY(a_out_from_finish, $rose(out_valid), $past(state == S_FINISH))
  `IAC_ASSERT_NEXT(a_carry_only_at_finish, state != S_FINISH, $stable(carry_flag))
  `IAC_ASSERT_IMPLY(a_fault_zero, out_valid && status != ST_OK, result_value == '0)
  `IAC_ASSERT_NEXT(a_mul_continues, state == S_MUL && cnt != '0, state == S_MUL)
  `IAC_ASSERT_NEXT(a_div_continues, state == S_DIV && cnt != '0, state == S_DIV)

endmodule

>>> verif/tb_integer_alu_with_carry.sv
// Self-checking testbench for integer_alu_with_carry: a directed table of corner cases, then
// random transactions with random idling on both channels, checked against a model of value, carry and status.
// Depends on iac_pkg and the integer_alu_with_carry RTL.
module tb_integer_alu_with_carry;
  import iac_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED_LO = 4'd10;
  localparam logic [OP_W-1:0]   OP_UNUSED_HI = 4'd15;
  localparam logic [DATA_W-1:0] ALL_ONES     = '1;
  localparam logic [DATA_W-1:0] SIGN_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int                RANDOM_ITEMS = 750;
  localparam int                CALM_ITEMS   = 100;
  localparam int                DRAIN_CYCLES = DEFAULT_WIDTH + 8;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic                carry;
    logic [STATUS_W-1:0] st;
  } alu_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                typed;
    alu_result_t       exp;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [DATA_W-1:0]   first_operand = '0;
  logic [DATA_W-1:0]   second_operand = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   result_value;
  logic                carry_out;
  logic [STATUS_W-1:0] status;

  bit          idling_on = 1'b1;
  int          stall_left = 0;
  int          mismatches = 0;
  logic        alu_carry = 1'b0;
  alu_result_t pending_results[$];
  stim_row_t   directed_rows[$];

  always #1 clk = ~clk;

  integer_alu_with_carry i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .first_operand (first_operand),
    .second_operand(second_operand),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_value  (result_value),
    .carry_out     (carry_out),
    .status        (status)
  );

  function automatic alu_result_t compute_alu_result(input logic [OP_W-1:0] op,
                                                     input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
    alu_result_t         r;
    logic [2*DATA_W-1:0] product;
    logic [DATA_W:0]     sum;
    r = '0;
    r.st = ST_OK;
    product = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    sum = {1'b0, a} + {1'b0, b};
    case (op)
      OP_ADD: begin
        r.value = sum[DATA_W-1:0];
        alu_carry = sum[DATA_W];
      end
      OP_SUB: begin
        r.value = a - b;
        alu_carry = (a < b);
      end
      OP_MUL: begin
        r.value = product[DATA_W-1:0];
        alu_carry = |product[2*DATA_W-1:DATA_W];
      end
      OP_DIV: begin
        if (b == '0) begin
          r.st = ST_DIVZERO;
        end else begin
          r.value = a / b;
          alu_carry = (a == SIGN_MIN && b == ALL_ONES);
        end
      end
      OP_MOD: begin
        if (b == '0) r.st = ST_DIVZERO;
        else r.value = a % b;
      end
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_LSH: begin
        if (b >= DATA_W) r.st = ST_SHIFT;
        else r.value = a << b;
      end
      OP_RSH: begin
        if (b < DATA_W) r.value = a >> b;
      end
      default: r.st = ST_UNHANDLED;
    endcase
    r.carry = alu_carry;
    return r;
  endfunction

  function automatic void push_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                                   input logic [DATA_W-1:0] b, input bit typed,
                                   input logic [DATA_W-1:0] value, input logic carry,
                                   input logic [STATUS_W-1:0] st);
    stim_row_t row;
    row.op = op;
    row.a = a;
    row.b = b;
    row.typed = typed;
    row.exp.value = value;
    row.exp.carry = carry;
    row.exp.st = st;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = SIGN_MIN;
      3: v = $urandom_range(0, 40);
      4: v = ALL_ONES >> $urandom_range(0, DATA_W-1);
      5: v = 32'd1 << $urandom_range(0, DATA_W-1);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_transaction(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                                  input logic [DATA_W-1:0] b, input bit typed,
                                  input alu_result_t typed_result);
    alu_result_t predicted;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    first_operand <= a;
    second_operand <= b;
    do @(posedge clk); while (in_stall);
    predicted = compute_alu_result(op, a, b);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  always @(posedge clk) begin
    if (rst || !idling_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19);
    end
  end

  always @(posedge clk) begin : result_check
    alu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: value %h carry %b status %0d",
                   result_value, carry_out, status);
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value || carry_out !== want.carry || status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%b/%0d, got %h/%b/%0d", want.value, want.carry,
                     want.st, result_value, carry_out, status);
        end
      end
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    alu_result_t       none;
    none = '0;

    push_row(OP_ADD, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_ADD, ALL_ONES, 32'h1, 1'b1, 32'h0, 1'b1, ST_OK);
    push_row(OP_ADD, ALL_ONES, ALL_ONES, 1'b1, 32'hFFFF_FFFE, 1'b1, ST_OK);
    push_row(OP_SUB, 32'h0, 32'h1, 1'b1, ALL_ONES, 1'b1, ST_OK);
    push_row(OP_SUB, 32'h5, 32'h5, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_MUL, ALL_ONES, ALL_ONES, 1'b1, 32'h1, 1'b1, ST_OK);
    push_row(OP_MUL, ALL_ONES, 32'h0, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_MUL, 32'h1_0000, 32'h1_0000, 1'b1, 32'h0, 1'b1, ST_OK);
    push_row(OP_DIV, SIGN_MIN, ALL_ONES, 1'b1, 32'h0, 1'b1, ST_OK);
    push_row(OP_DIV, 32'h7, 32'h0, 1'b1, 32'h0, 1'b1, ST_DIVZERO);
    push_row(OP_MOD, 32'h7, 32'h0, 1'b1, 32'h0, 1'b1, ST_DIVZERO);
    push_row(OP_DIV, ALL_ONES, 32'h1, 1'b1, ALL_ONES, 1'b0, ST_OK);
    push_row(OP_MOD, ALL_ONES, 32'd10, 1'b0, 32'h0, 1'b0, ST_OK);
    push_row(OP_AND, ALL_ONES, 32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0, ST_OK);
    push_row(OP_OR, 32'h0, ALL_ONES, 1'b1, ALL_ONES, 1'b0, ST_OK);
    push_row(OP_XOR, ALL_ONES, ALL_ONES, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_LSH, 32'h1, 32'd31, 1'b1, SIGN_MIN, 1'b0, ST_OK);
    push_row(OP_LSH, ALL_ONES, 32'd32, 1'b1, 32'h0, 1'b0, ST_SHIFT);
    push_row(OP_LSH, 32'h1, ALL_ONES, 1'b1, 32'h0, 1'b0, ST_SHIFT);
    push_row(OP_RSH, SIGN_MIN, 32'd31, 1'b1, 32'h1, 1'b0, ST_OK);
    push_row(OP_RSH, ALL_ONES, 32'd32, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_RSH, ALL_ONES, ALL_ONES, 1'b1, 32'h0, 1'b0, ST_OK);
    push_row(OP_UNUSED_LO, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0, ST_UNHANDLED);
    push_row(OP_ADD, ALL_ONES, 32'h2, 1'b1, 32'h1, 1'b1, ST_OK);
    push_row(OP_UNUSED_HI, ALL_ONES, ALL_ONES, 1'b1, 32'h0, 1'b1, ST_UNHANDLED);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_transaction(directed_rows[k].op, directed_rows[k].a, directed_rows[k].b,
                       directed_rows[k].typed, directed_rows[k].exp);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on <= (i < RANDOM_ITEMS - CALM_ITEMS) && ((i / 80) % 3 != 2);
      if ($urandom_range(0, 19) == 0) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else op = OP_W'($urandom_range(OP_ADD, OP_RSH));
      a = rand_operand();
      b = rand_operand();
      if ((op == OP_LSH || op == OP_RSH) && $urandom_range(0, 3) != 0)
        b = $urandom_range(0, DATA_W + 3);
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        a = SIGN_MIN;
        b = ALL_ONES;
      end
      send_transaction(op, a, b, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** integer_alu_with_carry: PASSED **");
    else
      $display("** integer_alu_with_carry: FAILED **");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** integer_alu_with_carry: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/iac_pkg.sv
rtl/core/integer_alu_with_carry.sv
verif/tb_integer_alu_with_carry.sv
